// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the indexed deque store.
// Each macro expects signals named clock and reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every cycle out of reset
`define CHK_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a condition implies another in the same cycle
`define CHK_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/idq_pkg.sv -----
// Shared types and constants for the indexed deque store.
// Used by idq_cell and indexed_deque_store; depends on nothing.
package idq_pkg;

   // default sizes
   localparam int DEPTH_DEF       = 128;
   localparam int ENTRY_WIDTH_DEF = 8;

   // fixed field widths of the channels
   localparam int CMD_W      = 3;
   localparam int POS_W      = 7;
   localparam int ENTRY_IO_W = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND  = 3'd0,
      CMD_PREPEND = 3'd1,
      CMD_READ    = 3'd2,
      CMD_REMOVE  = 3'd3,
      CMD_ROTATE  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FEW   = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // per-cycle controls broadcast to every cell
   typedef struct packed {
      logic append_en;
      logic prepend_en;
      logic remove_en;
      logic rotate_en;
      logic lane_load;
      logic lane_shift;
   } cell_ctl_type;

endpackage

// ----- rtl/idq_cell.sv -----
// One storage cell of the deque chain: holds one entry and one read-lane word.
// Depends on idq_pkg for the control struct and the position width.
module idq_cell #(
   parameter int IDX         = 0,
   parameter int CW          = 8,
   parameter int ENTRY_WIDTH = idq_pkg::ENTRY_WIDTH_DEF
) (
   input  logic                          clock,
   input  idq_pkg::cell_ctl_type         ctl,
   input  logic [CW-1:0]                 occ,
   input  logic [idq_pkg::POS_W-1:0]     pos,
   input  logic [ENTRY_WIDTH-1:0]        word,
   input  logic [ENTRY_WIDTH-1:0]        left_data,
   input  logic [ENTRY_WIDTH-1:0]        right_data,
   input  logic [ENTRY_WIDTH-1:0]        front_data,
   input  logic [ENTRY_WIDTH-1:0]        right_lane,
   output logic [ENTRY_WIDTH-1:0]        data_out,
   output logic [ENTRY_WIDTH-1:0]        lane_out
);

   localparam int XW = (CW > idq_pkg::POS_W) ? CW : idq_pkg::POS_W;
   localparam int IW = (XW > 11) ? XW : 11;

   localparam logic [IW-1:0] IDX_C    = IW'(IDX);
   localparam logic [IW-1:0] IDX_P1_C = IW'(IDX + 1);

   logic [ENTRY_WIDTH-1:0] data_ff, data_in;
   logic [ENTRY_WIDTH-1:0] lane_ff, lane_in;
   logic [IW-1:0]          occ_x, pos_x;

   assign occ_x = IW'(occ);
   assign pos_x = IW'(pos);

   // pick the next entry from the neighbors per command
   always_comb begin
      data_in = data_ff;
      if (ctl.append_en) begin
         if (IDX_C == occ_x) data_in = word;
      end else if (ctl.prepend_en) begin
         data_in = (IDX == 0) ? word : left_data;
      end else if (ctl.remove_en) begin
         if (IDX_C >= pos_x) data_in = right_data;
      end else if (ctl.rotate_en) begin
         if (IDX_P1_C < occ_x) data_in = right_data;
         else if (IDX_P1_C == occ_x) data_in = front_data;
      end
   end

   // read lane: copy all entries, then march toward the head
   always_comb begin
      lane_in = lane_ff;
      if (ctl.lane_load) lane_in = data_ff;
      else if (ctl.lane_shift) lane_in = right_lane;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      lane_ff <= lane_in;
   end

   assign data_out = data_ff;
   assign lane_out = lane_ff;

endmodule

// ----- rtl/indexed_deque_store.sv -----
// Indexed deque store: an ordered list of up to DEPTH words kept in a chain of cells.
// Commands arrive on req_* (command, position, entry_in); one result per command
// leaves on rsp_* (status, entry_out, count). Both use valid/ready handshakes.
// Append, insert at front and remove at index move each cell by at most one place,
// and rotate moves the head entry to the tail; the result is registered, and a
// new command is taken each cycle while the result register drains.
// Read at index copies the chain into a read lane and shifts it toward cell 0,
// one cell per cycle, and no command is taken during the shift or until the word
// is loaded into the result register. The lane shift sets the read rate.
// Refused commands (full, index out of range, too few to rotate) report status
// and leave the list unchanged; unused command codes report ok with no change.
// Reset empties the list (count 0) and drops any pending result; entry words
// need no clearing. When rsp_ready is low the result holds and req_ready falls
// until the result register can be reloaded.
// Depends on idq_pkg, idq_cell and assert_macros.svh.
`include "assert_macros.svh"

module indexed_deque_store #(
   parameter int DEPTH       = idq_pkg::DEPTH_DEF,
   parameter int ENTRY_WIDTH = idq_pkg::ENTRY_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [idq_pkg::CMD_W-1:0]       req_command,
   input  logic [idq_pkg::POS_W-1:0]       req_position,
   input  logic [idq_pkg::ENTRY_IO_W-1:0]  req_entry_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [idq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [idq_pkg::ENTRY_IO_W-1:0]  rsp_entry_out,
   output logic [idq_pkg::COUNT_W-1:0]     rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > idq_pkg::POS_W) ? CW : idq_pkg::POS_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] TWO_C   = CW'(2);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // control state
   idq_pkg::state_type            state_ff, state_in;
   logic [CW-1:0]                 occ_ff, occ_in;
   logic [idq_pkg::POS_W-1:0]     cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [idq_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [idq_pkg::ENTRY_IO_W-1:0] rsp_entry_out_ff, rsp_entry_out_in;
   logic [idq_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   idq_pkg::cell_ctl_type         ctl;
   idq_pkg::cmd_type              cmd;
   logic                          accept, out_free, is_full, pos_ok, too_few;
   logic [ENTRY_WIDTH-1:0]        word;

   logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
   logic [ENTRY_WIDTH-1:0] cell_lane [DEPTH];

   assign cmd      = idq_pkg::cmd_type'(req_command);
   assign word     = ENTRY_WIDTH'(req_entry_in);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == idq_pkg::S_IDLE) && out_free;
   assign accept   = req_valid && req_ready;
   assign is_full  = (occ_ff == DEPTH_C);
   assign pos_ok   = XW'(req_position) < XW'(occ_ff);
   assign too_few  = (occ_ff < TWO_C);

   // decode the command, steer the cells and load the result register
   always_comb begin
      state_in         = state_ff;
      occ_in           = occ_ff;
      cnt_in           = cnt_ff;
      ctl              = '0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_entry_out_in = rsp_entry_out_ff;
      rsp_count_in     = rsp_count_ff;
      unique case (state_ff)
         idq_pkg::S_IDLE: begin
            if (accept) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = idq_pkg::STAT_OK;
               rsp_entry_out_in = '0;
               unique case (cmd)
                  idq_pkg::CMD_APPEND: begin
                     if (is_full) rsp_status_in = idq_pkg::STAT_FULL;
                     else begin
                        ctl.append_en = 1'b1;
                        occ_in        = occ_ff + ONE_C;
                     end
                  end
                  idq_pkg::CMD_PREPEND: begin
                     if (is_full) rsp_status_in = idq_pkg::STAT_FULL;
                     else begin
                        ctl.prepend_en = 1'b1;
                        occ_in         = occ_ff + ONE_C;
                     end
                  end
                  idq_pkg::CMD_READ: begin
                     if (!pos_ok) rsp_status_in = idq_pkg::STAT_RANGE;
                     else begin
                        // hold the result until the lane delivers the word
                        rsp_valid_in  = 1'b0;
                        ctl.lane_load = 1'b1;
                        cnt_in        = req_position;
                        state_in      = idq_pkg::S_SCAN;
                     end
                  end
                  idq_pkg::CMD_REMOVE: begin
                     if (!pos_ok) rsp_status_in = idq_pkg::STAT_RANGE;
                     else begin
                        ctl.remove_en = 1'b1;
                        occ_in        = occ_ff - ONE_C;
                     end
                  end
                  idq_pkg::CMD_ROTATE: begin
                     if (too_few) rsp_status_in = idq_pkg::STAT_FEW;
                     else ctl.rotate_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = idq_pkg::COUNT_W'(occ_in);
            end
         end
         idq_pkg::S_SCAN: begin
            if (cnt_ff != '0) begin
               ctl.lane_shift = 1'b1;
               cnt_in         = cnt_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = idq_pkg::STAT_OK;
               rsp_entry_out_in = idq_pkg::ENTRY_IO_W'(cell_lane[0]);
               rsp_count_in     = idq_pkg::COUNT_W'(occ_ff);
               state_in         = idq_pkg::S_IDLE;
            end
         end
         default: state_in = idq_pkg::S_IDLE;
      endcase
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idq_pkg::S_IDLE;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_entry_out_ff <= rsp_entry_out_in;
      rsp_count_ff     <= rsp_count_in;
   end

   // chain of cells, each wired to its left and right neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] left_d, right_d, right_l;
      if (i == 0) begin : g_head
         assign left_d = '0;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_d = '0;
         assign right_l = '0;
      end else begin : g_body
         assign right_d = cell_data[i+1];
         assign right_l = cell_lane[i+1];
      end
      idq_cell #(
         .IDX         (i),
         .CW          (CW),
         .ENTRY_WIDTH (ENTRY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occ        (occ_ff),
         .pos        (req_position),
         .word       (word),
         .left_data  (left_d),
         .right_data (right_d),
         .front_data (cell_data[0]),
         .right_lane (right_l),
         .data_out   (cell_data[i]),
         .lane_out   (cell_lane[i])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_entry_out = rsp_entry_out_ff;
   assign rsp_count     = rsp_count_ff;

   `CHK_ALWAYS(a_occ_bound, occ_ff <= DEPTH_C, "occupancy beyond depth")
   `CHK_IMPLIES(a_count_match, rsp_valid_ff,
      rsp_count_ff == idq_pkg::COUNT_W'(occ_ff), "count mismatch")
   `CHK_IMPLIES(a_full_flag, rsp_valid_ff && (rsp_status_ff == idq_pkg::STAT_FULL),
      occ_ff == DEPTH_C, "full without full store")
   `CHK_NEXT(a_scan_count, (state_ff == idq_pkg::S_SCAN) && (cnt_ff != '0),
      cnt_ff == $past(cnt_ff) - 1'b1, "lane count slipped")

endmodule
